@@ rtl/lu_factorizer_no_pivot_top_defines.svh @@
// Assertion macros used by the LU factorizer RTL
`ifndef LU_FACTORIZER_NO_PIVOT_TOP_DEFINES_SVH
`define LU_FACTORIZER_NO_PIVOT_TOP_DEFINES_SVH

// check that a condition implies another in the same cycle
`define LU_ASSERT_IMPLIES(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lu check failed");

// check that a condition implies another in the next cycle
`define LU_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lu check failed");

`endif

@@ rtl/lu_pkg.sv @@
// Types, constants and helpers of the LU factorizer
package lu_pkg;

   localparam int ADDR_W = 6;
   localparam int DATA_W = 32;
   localparam int IDX_W  = 3;
   localparam int SIZE_W = 4;
   localparam int TOL_W  = 31;
   localparam int CNT_W  = 7;
   localparam int QBITS  = 48;

   localparam logic [DATA_W-1:0] Q_ONE  = 32'h0001_0000;
   localparam logic [DATA_W-1:0] Q_ZERO = 32'h0000_0000;
   localparam logic [DATA_W-1:0] Q_MAX  = 32'h7FFF_FFFF;
   localparam logic [DATA_W-1:0] Q_MIN  = 32'h8000_0000;

   typedef enum logic [0:0] {
      CSR_SIZE = 1'b0,
      CSR_TOL  = 1'b1
   } csr_idx_type;

   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] value;
      logic              last;
      logic [SIZE_W-1:0] order;
   } load_item_type;

   typedef struct packed {
      logic [IDX_W-1:0]  row;
      logic [IDX_W-1:0]  col;
      logic [DATA_W-1:0] lower;
      logic [DATA_W-1:0] upper;
      logic              status;
      logic              last;
   } rsp_item_type;

   typedef struct packed {
      logic              start;
      logic [DATA_W-1:0] num;
      logic [DATA_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic              busy;
      logic              done;
      logic [DATA_W-1:0] quot;
   } div_rsp_type;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_PIV_RD,
      ST_PIV_CHK,
      ST_DIV_RD,
      ST_DIV_LD,
      ST_DIV_RUN,
      ST_MUL_RD0,
      ST_MUL_RD1,
      ST_MUL_UPD,
      ST_OUT_RD,
      ST_OUT_WR
   } back_state_type;

   function automatic logic [DATA_W-1:0] sat32(input logic signed [63:0] v);
      logic [DATA_W-1:0] r;
      if (v > 64'sd2147483647) r = Q_MAX;
      else if (v < -64'sd2147483648) r = Q_MIN;
      else r = v[DATA_W-1:0];
      return r;
   endfunction

endpackage

@@ rtl/lu_factorizer_no_pivot_top.sv @@
// LU factorizer without pivoting: registers, queues, load side and elimination engine
// Elements enter row-major, one per item, into a four-entry queue and are stored one at a
// time. After the last element the engine reads and then checks each pivot, and eliminates
// with one shared serial divider (one quotient per row below each pivot) and one
// multiply-subtract that reads, multiplies and writes back each updated element, then emits
// n*n results, each read and then written, from the factor memories through a two-entry
// result queue, stalling while it is full. Input items are still taken while the input
// queue has room. A singular pivot ends the run with one result.
module lu_factorizer_no_pivot_top #(
   parameter int MAX_ORDER = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [31:0] req_elem_value,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [2:0]  rsp_out_row,
   output logic [2:0]  rsp_out_col,
   output logic [31:0] rsp_lower_value,
   output logic [31:0] rsp_upper_value,
   output logic        rsp_status,
   output logic        rsp_last_result,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [30:0] csr_wdata
);
   import lu_pkg::*;

   logic [SIZE_W-1:0] size_ff;
   logic [TOL_W-1:0]  tol_ff;
   logic              mid_push, mid_full, mid_pop, mid_empty;
   load_item_type     mid_in, mid_out;
   logic              out_push, out_full;
   rsp_item_type      out_in, out_head;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_W'(8);
         tol_ff  <= TOL_W'(1);
      end else if (csr_we) begin
         unique case (csr_idx_type'(csr_index))
            CSR_SIZE: size_ff <= csr_wdata[SIZE_W-1:0];
            CSR_TOL:  tol_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   lu_front #(.MAX_ORDER(MAX_ORDER)) u_front (
      .clock(clock), .reset(reset), .req_push(req_push), .req_elem_value(req_elem_value),
      .cfg_size(size_ff), .q_full(mid_full), .q_push(mid_push), .q_item(mid_in)
   );

   assign req_full = mid_full;

   lu_fifo #(.WIDTH($bits(load_item_type)), .DEPTH(4)) u_mid (
      .clock(clock), .reset(reset), .push(mid_push), .wdata(mid_in), .full(mid_full),
      .pop(mid_pop), .rdata(mid_out), .empty(mid_empty)
   );

   lu_back #(.MAX_ORDER(MAX_ORDER)) u_back (
      .clock(clock), .reset(reset), .cfg_tol(tol_ff), .q_empty(mid_empty),
      .q_item(mid_out), .q_pop(mid_pop), .rsp_full(out_full), .rsp_push(out_push),
      .rsp_item(out_in)
   );

   lu_fifo #(.WIDTH($bits(rsp_item_type)), .DEPTH(2)) u_out (
      .clock(clock), .reset(reset), .push(out_push), .wdata(out_in), .full(out_full),
      .pop(rsp_pop), .rdata(out_head), .empty(rsp_empty)
   );

   assign rsp_out_row     = out_head.row;
   assign rsp_out_col     = out_head.col;
   assign rsp_lower_value = out_head.lower;
   assign rsp_upper_value = out_head.upper;
   assign rsp_status      = out_head.status;
   assign rsp_last_result = out_head.last;
endmodule

@@ rtl/lu_ram.sv @@
// Generic single write, single registered read RAM
module lu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

@@ rtl/lu_fifo.sv @@
// Small register queue with push and pop sides
module lu_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] data_ff [DEPTH];
   logic [PTR_W-1:0] wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = data_ff[rptr_ff];

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wptr_in = (wptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (!do_push && do_pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
      if (do_push) begin
         data_ff[wptr_ff] <= wdata;
      end
   end
endmodule

@@ rtl/lu_div.sv @@
// Iterative Q16.16 divider with saturation, one quotient bit per cycle
module lu_div (
   input  logic                clock,
   input  logic                reset,
   input  lu_pkg::div_req_type req,
   output lu_pkg::div_rsp_type rsp
);
   import lu_pkg::*;

   logic             busy_ff, done_ff;
   logic [5:0]       cnt_ff;
   logic [DATA_W:0]  rem_ff, rem_in;
   logic [QBITS-1:0] quo_ff, quo_in;
   logic [DATA_W-1:0] dvs_ff;
   logic             neg_ff, nzero_ff, nneg_ff, dzero_ff;
   logic [DATA_W-1:0] num_mag, den_mag, quot;
   logic [DATA_W:0]  shifted;

   assign num_mag = req.num[DATA_W-1] ? DATA_W'(-req.num) : req.num;
   assign den_mag = req.den[DATA_W-1] ? DATA_W'(-req.den) : req.den;

   always_comb begin
      shifted = {rem_ff[DATA_W-1:0], quo_ff[QBITS-1]};
      if (shifted >= {1'b0, dvs_ff}) begin
         rem_in = shifted - {1'b0, dvs_ff};
         quo_in = {quo_ff[QBITS-2:0], 1'b1};
      end else begin
         rem_in = shifted;
         quo_in = {quo_ff[QBITS-2:0], 1'b0};
      end
   end

   always_comb begin
      if (dzero_ff) begin
         quot = nzero_ff ? Q_ZERO : (nneg_ff ? Q_MIN : Q_MAX);
      end else if (neg_ff) begin
         quot = (quo_ff > QBITS'(33'h0_8000_0000)) ? Q_MIN : DATA_W'(-quo_ff);
      end else begin
         quot = (quo_ff > QBITS'(Q_MAX)) ? Q_MAX : quo_ff[DATA_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == 6'(QBITS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
      if (req.start) begin
         rem_ff   <= '0;
         quo_ff   <= {num_mag, 16'h0000};
         dvs_ff   <= den_mag;
         neg_ff   <= req.num[DATA_W-1] ^ req.den[DATA_W-1];
         nzero_ff <= (req.num == '0);
         nneg_ff  <= req.num[DATA_W-1];
         dzero_ff <= (req.den == '0);
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign rsp.busy = busy_ff;
   assign rsp.done = done_ff;
   assign rsp.quot = quot;
endmodule

@@ rtl/lu_front.sv @@
// Load side: counts elements, tags the last one of a matrix and queues items
module lu_front #(
   parameter int MAX_ORDER = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_push,
   input  logic [31:0]             req_elem_value,
   input  logic [lu_pkg::SIZE_W-1:0] cfg_size,
   input  logic                    q_full,
   output logic                    q_push,
   output lu_pkg::load_item_type   q_item
);
   import lu_pkg::*;

   logic [CNT_W-1:0]  count_ff, count_in, count_inc;
   logic [SIZE_W-1:0] order;
   logic [CNT_W-1:0]  total;
   logic              last;

   always_comb begin
      if (cfg_size == '0) order = SIZE_W'(1);
      else if (cfg_size > SIZE_W'(MAX_ORDER)) order = SIZE_W'(MAX_ORDER);
      else order = cfg_size;
   end

   assign total     = CNT_W'(order) * CNT_W'(order);
   assign count_inc = count_ff + 1'b1;
   assign last      = (count_inc >= total);
   assign q_push    = req_push && !q_full;

   assign q_item.addr  = count_ff[ADDR_W-1:0];
   assign q_item.value = req_elem_value;
   assign q_item.last  = last;
   assign q_item.order = order;

   always_comb begin
      count_in = count_ff;
      if (q_push) begin
         count_in = last ? '0 : count_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end
endmodule

@@ rtl/lu_back.sv @@
// Elimination engine: stores elements, eliminates, then streams L and U
`include "lu_factorizer_no_pivot_top_defines.svh"
module lu_back #(
   parameter int MAX_ORDER = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [lu_pkg::TOL_W-1:0]  cfg_tol,
   input  logic                      q_empty,
   input  lu_pkg::load_item_type     q_item,
   output logic                      q_pop,
   input  logic                      rsp_full,
   output logic                      rsp_push,
   output lu_pkg::rsp_item_type      rsp_item
);
   import lu_pkg::*;

   localparam int DEPTH = MAX_ORDER * MAX_ORDER;
   localparam int AW    = $clog2(DEPTH);

   back_state_type state_ff, state_in;
   logic [SIZE_W-1:0] n_ff, n_in, k_ff, k_in, i_ff, i_in, j_ff, j_in;
   logic [DATA_W-1:0] p_ff, p_in, f_ff, f_in;
   logic signed [63:0] prod_ff, prod_in;

   logic              u_we, l_we;
   logic [ADDR_W-1:0] u_waddr, u_raddr, l_waddr, l_raddr;
   logic [DATA_W-1:0] u_wdata, u_rdata, l_rdata;
   div_req_type       div_req;
   div_rsp_type       div_rsp;

   logic [DATA_W:0]   p_mag;
   logic              singular;
   logic signed [63:0] scaled, diff;
   logic              k_more, i_more, j_more, at_end;

   function automatic logic [ADDR_W-1:0] pos(input logic [SIZE_W-1:0] r,
                                            input logic [SIZE_W-1:0] c,
                                            input logic [SIZE_W-1:0] n);
      return ADDR_W'(r) * ADDR_W'(n) + ADDR_W'(c);
   endfunction

   lu_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_upper (
      .clock(clock), .we(u_we), .waddr(u_waddr[AW-1:0]), .wdata(u_wdata),
      .raddr(u_raddr[AW-1:0]), .rdata(u_rdata)
   );

   lu_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_lower (
      .clock(clock), .we(l_we), .waddr(l_waddr[AW-1:0]), .wdata(f_in),
      .raddr(l_raddr[AW-1:0]), .rdata(l_rdata)
   );

   lu_div u_div (.clock(clock), .reset(reset), .req(div_req), .rsp(div_rsp));

   assign p_mag    = u_rdata[DATA_W-1] ? (DATA_W+1)'(-{u_rdata[DATA_W-1], u_rdata})
                                       : {1'b0, u_rdata};
   assign singular = (p_mag < {2'b00, cfg_tol});
   assign scaled   = (prod_ff < 0) ? ((prod_ff + 64'sd65535) >>> 16) : (prod_ff >>> 16);
   assign diff     = {{32{u_rdata[DATA_W-1]}}, u_rdata} - scaled;
   assign k_more   = (k_ff + 1'b1) < n_ff;
   assign i_more   = (i_ff + 1'b1) < n_ff;
   assign j_more   = (j_ff + 1'b1) < n_ff;
   assign at_end   = !i_more && !j_more;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD:    if (!q_empty && q_item.last) state_in = ST_PIV_RD;
         ST_PIV_RD:  state_in = ST_PIV_CHK;
         ST_PIV_CHK: begin
            if (singular) begin
               if (!rsp_full) state_in = ST_LOAD;
            end else if (k_more) begin
               state_in = ST_DIV_RD;
            end else begin
               state_in = ST_OUT_RD;
            end
         end
         ST_DIV_RD:  state_in = ST_DIV_LD;
         ST_DIV_LD:  state_in = ST_DIV_RUN;
         ST_DIV_RUN: if (div_rsp.done) state_in = ST_MUL_RD0;
         ST_MUL_RD0: state_in = ST_MUL_RD1;
         ST_MUL_RD1: state_in = ST_MUL_UPD;
         ST_MUL_UPD: begin
            if (j_more) state_in = ST_MUL_RD0;
            else if (i_more) state_in = ST_DIV_RD;
            else state_in = ST_PIV_RD;
         end
         ST_OUT_RD:  state_in = ST_OUT_WR;
         ST_OUT_WR:  if (!rsp_full) state_in = at_end ? ST_LOAD : ST_OUT_RD;
         default:    state_in = ST_LOAD;
      endcase
   end

   always_comb begin
      n_in = n_ff;  k_in = k_ff;  i_in = i_ff;  j_in = j_ff;
      p_in = p_ff;  f_in = f_ff;  prod_in = prod_ff;
      q_pop = 1'b0;
      u_we = 1'b0;  u_waddr = pos(i_ff, j_ff, n_ff);  u_wdata = sat32(diff);
      u_raddr = pos(i_ff, j_ff, n_ff);
      l_we = 1'b0;  l_waddr = pos(i_ff, k_ff, n_ff);  l_raddr = pos(i_ff, j_ff, n_ff);
      div_req.start = 1'b0;  div_req.num = u_rdata;  div_req.den = p_ff;
      rsp_push = 1'b0;
      rsp_item.row    = i_ff[IDX_W-1:0];
      rsp_item.col    = j_ff[IDX_W-1:0];
      rsp_item.lower  = (i_ff == j_ff) ? Q_ONE : ((i_ff < j_ff) ? Q_ZERO : l_rdata);
      rsp_item.upper  = (i_ff > j_ff) ? Q_ZERO : u_rdata;
      rsp_item.status = 1'b0;
      rsp_item.last   = at_end;
      unique case (state_ff)
         ST_LOAD: begin
            q_pop   = !q_empty;
            u_we    = !q_empty;
            u_waddr = q_item.addr;
            u_wdata = q_item.value;
            if (!q_empty && q_item.last) begin
               n_in = q_item.order;
               k_in = '0;
            end
         end
         ST_PIV_RD: u_raddr = pos(k_ff, k_ff, n_ff);
         ST_PIV_CHK: begin
            u_raddr = pos(k_ff, k_ff, n_ff);
            p_in    = u_rdata;
            if (singular) begin
               rsp_push        = !rsp_full;
               rsp_item.row    = k_ff[IDX_W-1:0];
               rsp_item.col    = k_ff[IDX_W-1:0];
               rsp_item.lower  = Q_ZERO;
               rsp_item.upper  = Q_ZERO;
               rsp_item.status = 1'b1;
               rsp_item.last   = 1'b1;
            end else if (k_more) begin
               i_in = k_ff + 1'b1;
            end else begin
               i_in = '0;
               j_in = '0;
            end
         end
         ST_DIV_RD: u_raddr = pos(i_ff, k_ff, n_ff);
         ST_DIV_LD: div_req.start = 1'b1;
         ST_DIV_RUN: begin
            if (div_rsp.done) begin
               f_in = div_rsp.quot;
               l_we = 1'b1;
               j_in = k_ff + 1'b1;
            end
         end
         ST_MUL_RD0: u_raddr = pos(k_ff, j_ff, n_ff);
         ST_MUL_RD1: prod_in = $signed(f_ff) * $signed(u_rdata);
         ST_MUL_UPD: begin
            u_we = 1'b1;
            if (j_more) begin
               j_in = j_ff + 1'b1;
            end else if (i_more) begin
               i_in = i_ff + 1'b1;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         ST_OUT_RD: ;
         ST_OUT_WR: begin
            rsp_push = !rsp_full;
            if (!rsp_full) begin
               if (j_more) begin
                  j_in = j_ff + 1'b1;
               end else begin
                  j_in = '0;
                  i_in = i_ff + 1'b1;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
      n_ff    <= n_in;
      k_ff    <= k_in;
      i_ff    <= i_in;
      j_ff    <= j_in;
      p_ff    <= p_in;
      f_ff    <= f_in;
      prod_ff <= prod_in;
   end

   `LU_ASSERT_IMPLIES(a_push_room, rsp_push, !rsp_full)
   `LU_ASSERT_IMPLIES(a_div_idle, div_req.start, !div_rsp.busy)
   `LU_ASSERT_IMPLIES(a_singular_last, rsp_push && rsp_item.status, rsp_item.last)
   `LU_ASSERT_NEXT(a_pop_only_loading, q_pop, state_ff == ST_PIV_RD || state_ff == ST_LOAD)
endmodule
